>>> sv/bcd_float_to_ascii_top_macros.svh
// Assertion macros shared by the BCD float to ASCII block.
// Expects clock aclk and active-low reset aresetn in the including module.
`ifndef BCD_FLOAT_TO_ASCII_TOP_MACROS_SVH
`define BCD_FLOAT_TO_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bfa_pkg.sv
// Types, constants and helpers for the BCD float to ASCII block.
// No dependencies; imported by every module of the block.
package bfa_pkg;

    localparam int MAX_MANTISSA_BYTES_DEF = 7;
    localparam int MANT_W                 = 56;
    localparam int NIB_W                  = 4;
    localparam int NUM_NIBS               = MANT_W / NIB_W;
    localparam logic [3:0] DIGITS_MAX     = 4'(NUM_NIBS);

    // ASCII codes used in the text
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_E     = 7'h45;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;

    // one output character
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } char_t;

    // sequencer to digit shift register
    typedef struct packed {
        logic load;
        logic shift;
    } dsr_ctrl_t;

    // digit shift register to sequencer
    typedef struct packed {
        logic [3:0] digit;
        logic       any_nz;
        logic       rest_nz;
    } dsr_stat_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } exp_dig_t;

    // split an exponent magnitude (0..65) into two decimal digits
    function automatic exp_dig_t exp_digits(input logic [6:0] v);
        exp_dig_t r;
        r.tens = 4'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= 7'(10 * k)) begin
                r.tens = 4'(k);
            end
        end
        r.ones = 4'(v - ({3'b000, r.tens} * 7'd10));
        return r;
    endfunction

endpackage

>>> sv/bfa_digit_sr.sv
// Mantissa nibble shift register with per-nibble nonzero flags.
// Depends on bfa_pkg.
module bfa_digit_sr import bfa_pkg::*; (
    input  logic              aclk,
    input  dsr_ctrl_t         ctrl,
    input  logic [MANT_W-1:0] mantissa,
    input  logic [2:0]        mant_bytes,
    output dsr_stat_t         stat
);

    logic [MANT_W-1:0]   dig_reg, dig_next;
    logic [NUM_NIBS-1:0] nz_reg, nz_next;
    logic [NUM_NIBS-1:0] nz_load;
    logic [3:0]          nib_count;

    // nonzero flags, unused nibbles forced clear
    assign nib_count = {mant_bytes, 1'b0};
    always_comb begin
        for (int i = 0; i < NUM_NIBS; i++) begin
            nz_load[NUM_NIBS-1-i] = (mantissa[MANT_W-1-NIB_W*i -: NIB_W] != '0) &&
                                    (4'(i) < nib_count);
        end
    end

    // load on a new number, shift one nibble per digit emitted
    always_comb begin
        dig_next = dig_reg;
        nz_next  = nz_reg;
        if (ctrl.load) begin
            dig_next = mantissa;
            nz_next  = nz_load;
        end else if (ctrl.shift) begin
            dig_next = {dig_reg[MANT_W-NIB_W-1:0], {NIB_W{1'b0}}};
            nz_next  = {nz_reg[NUM_NIBS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg <= dig_next;
        nz_reg  <= nz_next;
    end

    assign stat.digit   = dig_reg[MANT_W-1 -: NIB_W];
    assign stat.any_nz  = |nz_reg;
    assign stat.rest_nz = |nz_reg[NUM_NIBS-2:0];

endmodule

>>> sv/bfa_seq.sv
// Character sequencer: walks sign, digits, point and exponent of one number.
// Depends on bfa_pkg and bcd_float_to_ascii_top_macros.svh.
`include "bcd_float_to_ascii_top_macros.svh"

module bfa_seq import bfa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] exponent_byte,
    input  logic [2:0] mant_bytes,
    output dsr_ctrl_t  dsr_ctrl,
    input  dsr_stat_t  dsr_stat,
    output logic       gen_valid,
    output char_t      gen_char,
    input  logic       gen_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_SIGN, S_ZCHAR, S_LPT, S_LZERO, S_DIGIT,
        S_PT, S_EXP, S_ESIGN, S_ETENS, S_EONES
    } state_t;

    state_t            state_reg, state_next;
    logic [3:0]        j_reg, j_next;
    logic signed [6:0] e_reg;
    logic              sci_reg, zero_reg, neg_reg, mzero_reg, xneg_reg;
    logic [6:0]        xabs_reg;

    logic              load, emit, last;
    logic [6:0]        code;
    logic signed [7:0] e_ld8, x_ld8, two_m8, e8, jn8;
    logic [3:0]        jn;
    exp_dig_t          xdig;

    assign load      = in_valid && (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign gen_valid = (state_reg != S_IDLE);
    assign emit      = gen_valid && gen_ready;

    // exponent decode at load time
    assign e_ld8  = 8'(signed'({~exponent_byte[6], ~exponent_byte[6], exponent_byte[5:0]}));
    assign two_m8 = signed'({4'b0000, mant_bytes, 1'b0});
    assign x_ld8  = e_ld8 - 8'sd1;

    assign e8   = {e_reg[6], e_reg};
    assign jn   = j_reg + 4'd1;
    assign jn8  = signed'({4'b0000, jn});
    assign xdig = exp_digits(xabs_reg);

    // next character and next step
    always_comb begin
        state_next = state_reg;
        code       = CHAR_SPACE;
        last       = 1'b0;
        dsr_ctrl   = '0;
        j_next     = j_reg;
        case (state_reg)
            S_IDLE: begin
                if (load) state_next = S_SIGN;
            end
            S_SIGN: begin
                code = neg_reg ? CHAR_MINUS : CHAR_SPACE;
                if (zero_reg) begin
                    state_next = S_ZCHAR;
                end else if (sci_reg) begin
                    state_next = mzero_reg ? S_EXP : S_DIGIT;
                end else if (e8 <= 8'sd0) begin
                    // a lone point with no digits is dropped
                    if (e8 == 8'sd0 && mzero_reg) last = 1'b1;
                    else state_next = S_LPT;
                end else begin
                    state_next = S_DIGIT;
                end
            end
            S_ZCHAR: begin
                code = CHAR_ZERO;
                last = 1'b1;
            end
            S_LPT: begin
                code       = CHAR_DOT;
                state_next = (e8 == -8'sd1) ? S_LZERO : S_DIGIT;
            end
            S_LZERO: begin
                code = CHAR_ZERO;
                if (dsr_stat.any_nz) state_next = S_DIGIT;
                else last = 1'b1;
            end
            S_DIGIT: begin
                code           = CHAR_ZERO + {3'b000, dsr_stat.digit};
                dsr_ctrl.shift = emit;
                j_next         = jn;
                if (sci_reg) begin
                    if (dsr_stat.rest_nz) state_next = (j_reg == 4'd0) ? S_PT : S_DIGIT;
                    else state_next = S_EXP;
                end else if (jn8 < e8) begin
                    state_next = S_DIGIT;
                end else if (dsr_stat.rest_nz) begin
                    state_next = (jn8 == e8) ? S_PT : S_DIGIT;
                end else begin
                    last = 1'b1;
                end
            end
            S_PT: begin
                code       = CHAR_DOT;
                state_next = S_DIGIT;
            end
            S_EXP: begin
                code       = CHAR_E;
                state_next = S_ESIGN;
            end
            S_ESIGN: begin
                code       = xneg_reg ? CHAR_MINUS : CHAR_PLUS;
                state_next = S_ETENS;
            end
            S_ETENS: begin
                code       = CHAR_ZERO + {3'b000, xdig.tens};
                state_next = S_EONES;
            end
            S_EONES: begin
                code = CHAR_ZERO + {3'b000, xdig.ones};
                last = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (last) state_next = S_IDLE;
        dsr_ctrl.load = load;
    end

    assign gen_char.code = code;
    assign gen_char.last = last;

    // state and per-number registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            if (load || emit) state_reg <= state_next;
            if (emit) j_reg <= j_next;
            if (load) begin
                j_reg     <= 4'd0;
                e_reg     <= e_ld8[6:0];
                sci_reg   <= (e_ld8 > two_m8) || (e_ld8 < -8'sd1);
                zero_reg  <= (exponent_byte == 8'h00);
                neg_reg   <= exponent_byte[7];
                mzero_reg <= (mant_bytes == 3'd0);
                xneg_reg  <= x_ld8[7];
                xabs_reg  <= x_ld8[7] ? 7'(-x_ld8) : x_ld8[6:0];
            end
        end
    end

    `BFA_ASSERT_NEXT(a_last_to_idle, emit && gen_char.last, state_reg == S_IDLE, "last char did not end the number")
    `BFA_ASSERT_NOW(a_digit_range, state_reg == S_DIGIT, j_reg < DIGITS_MAX, "digit index past mantissa")
    `BFA_ASSERT_NEXT(a_zero_text, load && exponent_byte == 8'h00, state_reg == S_SIGN && zero_reg, "zero exponent not flagged")
    `BFA_ASSERT_NOW(a_sci_point, state_reg == S_PT && sci_reg, j_reg == 4'd1, "scientific point not after first digit")

endmodule

>>> sv/bfa_out_reg.sv
// Output register stage for the character stream.
// Depends on bfa_pkg.
module bfa_out_reg import bfa_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  char_t in_char,
    output logic  in_ready,
    output logic  out_valid,
    output char_t out_char,
    input  logic  out_ready
);

    logic  valid_reg, valid_next;
    char_t data_reg;

    // take a new char when empty or when the held one leaves
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) data_reg <= in_char;
    end

    assign out_valid = valid_reg;
    assign out_char  = data_reg;

endmodule

>>> sv/bcd_float_to_ascii_top.sv
// BCD float to ASCII text converter, top level.
// Depends on bfa_pkg, bfa_digit_sr, bfa_seq, bfa_out_reg.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_exponent_byte[7:0], s_mantissa[55:0]
//  m_       out        m_valid/m_ready    m_char_code[6:0], m_last_char
//  cfg_     in         cfg_wr_en          cfg_wr_data[2:0] (mantissa bytes)
//
// A number of n characters (1 to 20) is loaded first, then the sequencer gives one
// character per cycle while m_ready does not stall it, and steps the mantissa one
// nibble per digit through the digit shift register.
// Synchronous active-low reset; mantissa byte count resets to 7.
// A stalled m_ready holds the sequencer; s_ready is high only between numbers.
module bcd_float_to_ascii_top import bfa_pkg::*; #(
    parameter int MAX_MANTISSA_BYTES = MAX_MANTISSA_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_exponent_byte,
    input  logic [MANT_W-1:0] s_mantissa,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_char_code,
    output logic              m_last_char,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_data
);

    localparam logic [2:0] MAX_BYTES = 3'(MAX_MANTISSA_BYTES);

    logic [2:0] cfg_reg, cfg_next;
    logic [2:0] mant_bytes;
    dsr_ctrl_t  dsr_ctrl;
    dsr_stat_t  dsr_stat;
    logic       gen_valid, gen_ready;
    char_t      gen_char, out_char;

    // mantissa byte count register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) cfg_next = cfg_wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= 3'd7;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign mant_bytes = (cfg_reg > MAX_BYTES) ? MAX_BYTES : cfg_reg;

    bfa_digit_sr u_digit_sr (
        .aclk       (aclk),
        .ctrl       (dsr_ctrl),
        .mantissa   (s_mantissa),
        .mant_bytes (mant_bytes),
        .stat       (dsr_stat)
    );

    bfa_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .exponent_byte (s_exponent_byte),
        .mant_bytes    (mant_bytes),
        .dsr_ctrl      (dsr_ctrl),
        .dsr_stat      (dsr_stat),
        .gen_valid     (gen_valid),
        .gen_char      (gen_char),
        .gen_ready     (gen_ready)
    );

    bfa_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (gen_valid),
        .in_char   (gen_char),
        .in_ready  (gen_ready),
        .out_valid (m_valid),
        .out_char  (out_char),
        .out_ready (m_ready)
    );

    assign m_char_code = out_char.code;
    assign m_last_char = out_char.last;

endmodule
